/* rtl/core/ugnb_pkg.sv */
// Shared types and constants for the uniform grid neighbor binning block.
`default_nettype none
package ugnb_pkg;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_NONE  = 2'd3;

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE = 3'd2;
  localparam logic [2:0] REG_GRID_COLS = 3'd3;
  localparam logic [2:0] REG_GRID_ROWS = 3'd4;
  localparam logic [2:0] REG_BUCKET_LIMIT = 3'd5;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DIV,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_CELL,
    ST_Q_FILL,
    ST_Q_RD,
    ST_Q_EMIT,
    ST_Q_END
  } state_t;

  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [16:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

/* rtl/core/ugnb_divider.sv */
// Shared restoring divider: one quotient bit per cycle.
`default_nettype none
module ugnb_divider (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire ugnb_pkg::div_req_t req,
  input  wire logic [15:0]       divisor,
  output ugnb_pkg::div_rsp_t     rsp
);
  logic [16:0] quot;
  logic [16:0] rem;
  logic [4:0]  count;
  logic        busy;
  logic        done;
  logic [17:0] trial;

  assign trial = {rem, quot[16]} - {2'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        count <= 5'd0;
      end else if (busy) begin
        count <= count + 5'd1;
        if (count == 5'd16) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quot <= req.dividend;
      rem <= '0;
    end else if (busy) begin
      if (!trial[17]) begin
        rem <= trial[16:0];
        quot <= {quot[15:0], 1'b1};
      end else begin
        rem <= {rem[15:0], quot[16]};
        quot <= {quot[15:0], 1'b0};
      end
    end
  end

  assign rsp = {done, quot};
endmodule
`default_nettype wire

/* rtl/core/uniform_grid_neighbor_binning_top.sv */
// Top level of the uniform grid neighbor binning block.
// Input channel s_axis: tdata = {entity_handle, pos_z, pos_x, action} packed from bit 0,
// one transaction per command. Output channel m_axis: tdata = neighbor_handle,
// tuser = handle_valid, tlast = last. Clear and add give no output; a query gives
// every stored handle in the 3x3 cells round its cell, newest first, then an end
// marker with tlast high. Configuration writes (cfg_we/cfg_index/cfg_data) also empty
// all buckets; they are to be made only while the block is idle, which the block does not enforce.
// An item is worked on alone; s_axis_tready is low until it finishes.
// Clear and reset sweep the fill counters, one cell a cycle; the block takes no input
// during that pass.
// Add: two serial divisions for the cell, then the fill counter read and, if the cell
// lies in the grid, the write.
// Query: two serial divisions, then each neighbor cell outside the grid is skipped, each
// cell inside it has its fill counter read, each handle is read and sent, and the end
// marker follows. A query below the minimum or with zero cell size gives only the end marker.
// A stalled receiver holds the output register and the sequencer with it.
`default_nettype none
module uniform_grid_neighbor_binning_top #(
  parameter int GRID_DIM = 16,
  parameter int BUCKET_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,  // action[1:0], pos_x, pos_z, entity_handle
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,  // neighbor_handle
  output logic             m_axis_tuser,  // handle_valid
  output logic             m_axis_tlast,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int CB = (GRID_DIM > 1) ? $clog2(GRID_DIM) : 1;
  localparam int NCELL = GRID_DIM * GRID_DIM;
  localparam int AB = $clog2(NCELL) > 0 ? $clog2(NCELL) : 1;
  localparam int DB = (BUCKET_DEPTH > 1) ? $clog2(BUCKET_DEPTH) : 1;
  localparam int FB = $clog2(BUCKET_DEPTH + 1);

  logic signed [15:0] origin_x, origin_z;
  logic [15:0] cell_size;
  logic [4:0]  grid_cols, grid_rows;
  logic [2:0]  bucket_limit;

  ugnb_pkg::state_t state, state_next;
  logic [1:0]  action;
  logic [15:0] handle;
  logic signed [17:0] dx, dz;
  logic        phase_z;
  logic signed [17:0] cx, cz;
  logic [1:0]  ox, oz;
  logic [AB-1:0] cell_addr, sweep;
  logic [FB-1:0] fill;
  logic [DB:0]   n;
  logic        clear_req;

  logic [FB-1:0] fill_mem [NCELL];
  logic [15:0]   ent_mem [NCELL*BUCKET_DEPTH];
  logic [FB-1:0] fill_rd;
  logic [15:0]   ent_rd;

  ugnb_pkg::div_req_t dreq;
  ugnb_pkg::div_rsp_t drsp;

  ugnb_divider u_div (.clk(clk), .rst(rst), .req(dreq), .divisor(cell_size), .rsp(drsp));

  logic [FB-1:0] lim;
  logic [6:0]    cols_e, rows_e;
  assign lim = (bucket_limit > 3'(BUCKET_DEPTH)) ? FB'(BUCKET_DEPTH) : FB'(bucket_limit);
  assign cols_e = ({2'b0, grid_cols} > 7'(GRID_DIM)) ? 7'(GRID_DIM) : {2'b0, grid_cols};
  assign rows_e = ({2'b0, grid_rows} > 7'(GRID_DIM)) ? 7'(GRID_DIM) : {2'b0, grid_rows};

  // division operand: |d| or |d|+cs-1 for negative floor
  logic signed [17:0] dcur;
  logic [17:0] mag;
  assign dcur = phase_z ? dz : dx;
  assign mag = dz[17] ? 18'(-dz) + 18'(cell_size) - 18'd1 : 18'(dz);
  logic signed [17:0] qs;
  assign qs = dcur[17] ? -$signed({1'b0, drsp.quot}) : $signed({1'b0, drsp.quot});

  // start the first division straight from the input transaction
  logic signed [17:0] dx_in;
  logic [17:0] mag_in;
  assign dx_in = 18'(signed'(s_axis_tdata[17:2])) - 18'(origin_x);
  assign mag_in = dx_in[17] ? 18'(-dx_in) + 18'(cell_size) - 18'd1 : 18'(dx_in);

  logic signed [17:0] nx, nz;
  logic in_grid;
  assign nx = cx + 18'(ox) - 18'sd1;
  assign nz = cz + 18'(oz) - 18'sd1;
  assign in_grid = !nx[17] && !nz[17] && (nx < 18'(cols_e)) && (nz < 18'(rows_e));

  logic add_ok;
  assign add_ok = !cx[17] && !cz[17] && (cx < 18'(cols_e)) && (cz < 18'(rows_e));

  logic last_cell;
  assign last_cell = (ox == 2'd2) && (oz == 2'd2);

  logic emit_fire;
  assign emit_fire = m_axis_tvalid && m_axis_tready;

  always_comb begin
    state_next = state;
    unique case (state)
      ugnb_pkg::ST_IDLE:
        if (clear_req) state_next = ugnb_pkg::ST_CLEAR;
        else if (s_axis_tvalid) begin
          unique case (s_axis_tdata[1:0])
            ugnb_pkg::ACT_CLEAR: state_next = ugnb_pkg::ST_CLEAR;
            ugnb_pkg::ACT_ADD:
              state_next = (cell_size == 16'd0) ? ugnb_pkg::ST_IDLE : ugnb_pkg::ST_DIV;
            ugnb_pkg::ACT_QUERY:
              state_next = ugnb_pkg::ST_DIV;
            default: state_next = ugnb_pkg::ST_IDLE;
          endcase
        end
      ugnb_pkg::ST_CLEAR:
        if (sweep == AB'(NCELL - 1)) state_next = ugnb_pkg::ST_IDLE;
      ugnb_pkg::ST_DIV:
        if (action == ugnb_pkg::ACT_QUERY &&
            (cell_size == 16'd0 || dx[17] || dz[17])) state_next = ugnb_pkg::ST_Q_END;
        else if (drsp.done && phase_z)
          state_next = (action == ugnb_pkg::ACT_ADD) ? ugnb_pkg::ST_ADD_RD
                                                     : ugnb_pkg::ST_Q_CELL;
      ugnb_pkg::ST_ADD_RD:
        state_next = add_ok ? ugnb_pkg::ST_ADD_WR : ugnb_pkg::ST_IDLE;
      ugnb_pkg::ST_ADD_WR:
        state_next = ugnb_pkg::ST_IDLE;
      ugnb_pkg::ST_Q_CELL:
        if (in_grid) state_next = ugnb_pkg::ST_Q_FILL;
        else if (last_cell) state_next = ugnb_pkg::ST_Q_END;
      ugnb_pkg::ST_Q_FILL:
        if (fill_rd == '0) state_next = last_cell ? ugnb_pkg::ST_Q_END : ugnb_pkg::ST_Q_CELL;
        else state_next = ugnb_pkg::ST_Q_RD;
      ugnb_pkg::ST_Q_RD:
        state_next = ugnb_pkg::ST_Q_EMIT;
      ugnb_pkg::ST_Q_EMIT:
        if (emit_fire) begin
          if (n != '0) state_next = ugnb_pkg::ST_Q_RD;
          else state_next = last_cell ? ugnb_pkg::ST_Q_END : ugnb_pkg::ST_Q_CELL;
        end
      ugnb_pkg::ST_Q_END:
        if (emit_fire) state_next = ugnb_pkg::ST_IDLE;
      default: state_next = ugnb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state == ugnb_pkg::ST_IDLE) && !clear_req;
    m_axis_tvalid = (state == ugnb_pkg::ST_Q_EMIT) || (state == ugnb_pkg::ST_Q_END);
    m_axis_tdata = (state == ugnb_pkg::ST_Q_EMIT) ? ent_rd : 16'd0;
    m_axis_tuser = (state == ugnb_pkg::ST_Q_EMIT);
    m_axis_tlast = (state == ugnb_pkg::ST_Q_END);
    dreq.start = ((state == ugnb_pkg::ST_IDLE) && s_axis_tready && s_axis_tvalid &&
                  (s_axis_tdata[1:0] == ugnb_pkg::ACT_ADD ||
                   s_axis_tdata[1:0] == ugnb_pkg::ACT_QUERY)) ||
                 ((state == ugnb_pkg::ST_DIV) && drsp.done && !phase_z);
    dreq.dividend = (state == ugnb_pkg::ST_IDLE) ? 17'(mag_in) : 17'(mag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ugnb_pkg::ST_IDLE;
      clear_req <= 1'b1;
      origin_x <= '0;
      origin_z <= '0;
      cell_size <= 16'd1024;
      grid_cols <= 5'd16;
      grid_rows <= 5'd16;
      bucket_limit <= 3'd4;
    end else begin
      state <= state_next;
      if (state == ugnb_pkg::ST_CLEAR) clear_req <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          ugnb_pkg::REG_ORIGIN_X: begin origin_x <= cfg_data; clear_req <= 1'b1; end
          ugnb_pkg::REG_ORIGIN_Z: begin origin_z <= cfg_data; clear_req <= 1'b1; end
          ugnb_pkg::REG_CELL_SIZE: begin cell_size <= cfg_data; clear_req <= 1'b1; end
          ugnb_pkg::REG_GRID_COLS: begin grid_cols <= cfg_data[4:0]; clear_req <= 1'b1; end
          ugnb_pkg::REG_GRID_ROWS: begin grid_rows <= cfg_data[4:0]; clear_req <= 1'b1; end
          ugnb_pkg::REG_BUCKET_LIMIT: begin
            bucket_limit <= cfg_data[2:0];
            clear_req <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ugnb_pkg::ST_IDLE: begin
        action <= s_axis_tdata[1:0];
        dx <= dx_in;
        dz <= 18'(signed'(s_axis_tdata[33:18])) - 18'(origin_z);
        handle <= s_axis_tdata[49:34];
        phase_z <= 1'b0;
        sweep <= '0;
        ox <= 2'd0;
        oz <= 2'd0;
      end
      ugnb_pkg::ST_CLEAR: sweep <= sweep + AB'(1);
      ugnb_pkg::ST_DIV:
        if (drsp.done) begin
          if (phase_z) cz <= qs; else cx <= qs;
          phase_z <= 1'b1;
        end
      ugnb_pkg::ST_ADD_RD: cell_addr <= AB'(cz[CB-1:0]) * AB'(GRID_DIM) + AB'(cx[CB-1:0]);
      ugnb_pkg::ST_Q_CELL: begin
        cell_addr <= AB'(nz[CB-1:0]) * AB'(GRID_DIM) + AB'(nx[CB-1:0]);
        if (!in_grid) begin
          if (oz == 2'd2) begin oz <= 2'd0; ox <= ox + 2'd1; end
          else oz <= oz + 2'd1;
        end
      end
      ugnb_pkg::ST_Q_FILL: begin
        n <= (DB+1)'(fill_rd) - (DB+1)'(1);
        if (fill_rd == '0) begin
          if (oz == 2'd2) begin oz <= 2'd0; ox <= ox + 2'd1; end
          else oz <= oz + 2'd1;
        end
      end
      ugnb_pkg::ST_Q_EMIT:
        if (emit_fire) begin
          if (n != '0) n <= n - (DB+1)'(1);
          else if (oz == 2'd2) begin oz <= 2'd0; ox <= ox + 2'd1; end
          else oz <= oz + 2'd1;
        end
      default: ;
    endcase
  end

  // fill counter memory: read address is the add cell or the current neighbor cell, clear sweeps it
  logic [AB-1:0] faddr;
  assign faddr = (state == ugnb_pkg::ST_ADD_RD)
                 ? AB'(cz[CB-1:0]) * AB'(GRID_DIM) + AB'(cx[CB-1:0])
                 : AB'(nz[CB-1:0]) * AB'(GRID_DIM) + AB'(nx[CB-1:0]);
  always_ff @(posedge clk) begin
    if (state == ugnb_pkg::ST_CLEAR) fill_mem[sweep] <= '0;
    else if (state == ugnb_pkg::ST_ADD_WR && fill_rd < lim)
      fill_mem[cell_addr] <= fill_rd + FB'(1);
    fill_rd <= fill_mem[faddr];
  end
  assign fill = fill_rd;

  always_ff @(posedge clk) begin
    if (state == ugnb_pkg::ST_ADD_WR && fill < lim)
      ent_mem[cell_addr * (AB+DB)'(BUCKET_DEPTH) + (AB+DB)'(fill)] <= handle;
    ent_rd <= ent_mem[cell_addr * (AB+DB)'(BUCKET_DEPTH) + (AB+DB)'(n[DB-1:0])];
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> !m_axis_tvalid) else $error("ready while emitting");
  a_last_marker: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser && m_axis_tdata == 16'd0)
    else $error("bad end marker");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tlast))
    else $error("output dropped under stall");
`endif
endmodule
`default_nettype wire

/* tb/tb_uniform_grid_neighbor_binning_top.sv */
// Testbench for the uniform grid neighbor binning block: directed table, then random traffic.
`default_nettype none
module tb_uniform_grid_neighbor_binning_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM = 16;
  localparam int DEPTH = 4;
  localparam int CYCLE_LIMIT = 1500000;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [15:0] handle;
    logic        hvalid;
    logic        last;
  } neighbor_t;

  typedef struct {
    logic [1:0]  act;
    logic [15:0] px;
    logic [15:0] pz;
    logic [15:0] eh;
    logic        chk;
    logic [15:0] exp_handle;
  } cmd_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  uniform_grid_neighbor_binning_top u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // mirror of the grid
  logic signed [15:0] m_ox, m_oz;
  logic [15:0] m_cs;
  logic [4:0]  m_cols, m_rows;
  logic [2:0]  m_lim;
  logic [2:0]  fill_mem [DIM*DIM];
  logic [15:0] entry_mem [DIM*DIM*DEPTH];

  neighbor_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet = 0;

  function automatic int floor_div(int d, int cs);
    if (d >= 0) return d / cs;
    return -((-d + cs - 1) / cs);
  endfunction

  function automatic void empty_grid();
    foreach (fill_mem[i]) fill_mem[i] = '0;
  endfunction

  function automatic void grid_apply(logic [1:0] act, logic [15:0] px, logic [15:0] pz,
                                     logic [15:0] eh);
    int dx, dz, cx, cz, cols, rows, lim, cell_idx, n, x, z;
    neighbor_t r;
    dx = int'($signed(px)) - int'(m_ox);
    dz = int'($signed(pz)) - int'(m_oz);
    cols = (m_cols > DIM) ? DIM : int'(m_cols);
    rows = (m_rows > DIM) ? DIM : int'(m_rows);
    lim = (m_lim > DEPTH) ? DEPTH : int'(m_lim);
    if (act == ugnb_pkg::ACT_CLEAR) begin
      empty_grid();
    end else if (act == ugnb_pkg::ACT_ADD) begin
      if (m_cs != 0) begin
        cx = floor_div(dx, int'(m_cs));
        cz = floor_div(dz, int'(m_cs));
        if (cx >= 0 && cx < cols && cz >= 0 && cz < rows) begin
          cell_idx = cz * DIM + cx;
          if (fill_mem[cell_idx] < lim) begin
            entry_mem[cell_idx*DEPTH + int'(fill_mem[cell_idx])] = eh;
            fill_mem[cell_idx] = 3'(fill_mem[cell_idx] + 3'd1);
          end
        end
      end
    end else if (act == ugnb_pkg::ACT_QUERY) begin
      if (m_cs != 0 && dx >= 0 && dz >= 0) begin
        cx = floor_div(dx, int'(m_cs));
        cz = floor_div(dz, int'(m_cs));
        for (int i = -1; i <= 1; i++)
          for (int j = -1; j <= 1; j++) begin
            x = cx + i;
            z = cz + j;
            if (x < 0 || x >= cols || z < 0 || z >= rows) continue;
            cell_idx = z * DIM + x;
            n = (fill_mem[cell_idx] > DEPTH) ? DEPTH : int'(fill_mem[cell_idx]);
            while (n > 0) begin
              n--;
              r.handle = entry_mem[cell_idx*DEPTH + n];
              r.hvalid = 1'b1;
              r.last = 1'b0;
              expected_q.push_back(r);
            end
          end
      end
      r.handle = '0;
      r.hvalid = 1'b0;
      r.last = 1'b1;
      expected_q.push_back(r);
    end
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ugnb_pkg::REG_ORIGIN_X:     m_ox = val;
      ugnb_pkg::REG_ORIGIN_Z:     m_oz = val;
      ugnb_pkg::REG_CELL_SIZE:    m_cs = val;
      ugnb_pkg::REG_GRID_COLS:    m_cols = val[4:0];
      ugnb_pkg::REG_GRID_ROWS:    m_rows = val[4:0];
      ugnb_pkg::REG_BUCKET_LIMIT: m_lim = val[2:0];
      default: ;
    endcase
    if (idx <= ugnb_pkg::REG_BUCKET_LIMIT) empty_grid();
    // hold for the bucket sweep that a write to a defined register triggers
    repeat (DIM*DIM + 20) @(posedge clk);
  endtask

  task automatic drain_and_settle();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DIM*DIM + 100) @(posedge clk);
  endtask

  task automatic send_cmd(logic [1:0] act, logic [15:0] px, logic [15:0] pz, logic [15:0] eh);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'b0, eh, pz, px, act};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    grid_apply(act, px, pz, eh);
  endtask

  // receiver with random stalls
  int stall_left = 0;
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      neighbor_t got, want;
      got = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
      if (expected_q.size() == 0) begin
        $error("unexpected result handle=%h", m_axis_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.handle !== want.handle) begin
          $error("neighbor_handle expected %h actual %h", want.handle, got.handle);
          errors++;
        end
        if (got.hvalid !== want.hvalid) begin
          $error("handle_valid expected %b actual %b", want.hvalid, got.hvalid);
          errors++;
        end
        if (got.last !== want.last) begin
          $error("last expected %b actual %b", want.last, got.last);
          errors++;
        end
      end
    end
    if (quiet) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 8);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  cmd_t dir_tab[] = '{
    '{ugnb_pkg::ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000},
    '{ugnb_pkg::ACT_ADD,   16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_ADD,   16'h0100, 16'h0100, 16'hFFFF, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_ADD,   16'h0200, 16'h0000, 16'h1234, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_ADD,   16'h0300, 16'h0300, 16'hABCD, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_ADD,   16'h0000, 16'h0000, 16'h5555, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_ADD,   16'h0000, 16'h0000, 16'hAAAA, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_ADD,   16'h0000, 16'h0000, 16'h0F0F, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_QUERY, 16'h0080, 16'h0080, 16'h0000, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_QUERY, 16'h0400, 16'h0400, 16'h0000, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_QUERY, 16'h8000, 16'h0000, 16'h0000, 1'b1, 16'h0000},
    '{ugnb_pkg::ACT_QUERY, 16'h0000, 16'h8000, 16'h0000, 1'b1, 16'h0000},
    '{ugnb_pkg::ACT_ADD,   16'h7FFF, 16'h7FFF, 16'h0001, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_ADD,   16'h3C00, 16'h3C00, 16'h0002, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_QUERY, 16'h7FFF, 16'h7FFF, 16'h0000, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_QUERY, 16'h3C00, 16'h3C00, 16'h0000, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_NONE,  16'h0000, 16'h0000, 16'h9999, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_CLEAR, 16'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_QUERY, 16'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000},
    '{ugnb_pkg::ACT_ADD,   16'hFFFF, 16'h0000, 16'h7777, 1'b0, 16'h0},
    '{ugnb_pkg::ACT_QUERY, 16'h0100, 16'h0100, 16'h0000, 1'b0, 16'h0}
  };

  task automatic random_phase(int n, int span);
    logic [1:0] act;
    logic [15:0] px, pz;
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      if (r < 55) act = ugnb_pkg::ACT_ADD;
      else if (r < 92) act = ugnb_pkg::ACT_QUERY;
      else if (r < 96) act = ugnb_pkg::ACT_CLEAR;
      else act = ugnb_pkg::ACT_NONE;
      if ($urandom_range(0, 9) == 0) begin
        px = 16'($urandom);
        pz = 16'($urandom);
      end else begin
        px = 16'(m_ox + $urandom_range(0, span));
        pz = 16'(m_oz + $urandom_range(0, span));
      end
      send_cmd(act, px, pz, 16'($urandom));
    end
  endtask

  initial begin
    cmd_t c;
    m_ox = 0; m_oz = 0; m_cs = 1024; m_cols = 16; m_rows = 16; m_lim = 4;
    empty_grid();
    foreach (entry_mem[i]) entry_mem[i] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    repeat (DIM*DIM + 20) @(posedge clk);

    foreach (dir_tab[i]) begin
      c = dir_tab[i];
      send_cmd(c.act, c.px, c.pz, c.eh);
      if (c.chk && expected_q.size() != 0) begin
        if (expected_q[$].handle !== c.exp_handle || expected_q[$].last !== 1'b1) begin
          $error("directed row %0d end marker mismatch", i);
          errors++;
        end
      end
    end
    drain_and_settle();

    // small grid, low limit, odd origin
    write_reg(ugnb_pkg::REG_ORIGIN_X, 16'h8000);
    write_reg(ugnb_pkg::REG_ORIGIN_Z, 16'h7F00);
    write_reg(ugnb_pkg::REG_CELL_SIZE, 16'h0001);
    write_reg(ugnb_pkg::REG_GRID_COLS, 16'd1);
    write_reg(ugnb_pkg::REG_GRID_ROWS, 16'd3);
    write_reg(ugnb_pkg::REG_BUCKET_LIMIT, 16'd1);
    random_phase(40, 4);
    drain_and_settle();

    // saturating sizes, zero limit
    write_reg(ugnb_pkg::REG_ORIGIN_X, 16'hFF00);
    write_reg(ugnb_pkg::REG_ORIGIN_Z, 16'h0000);
    write_reg(ugnb_pkg::REG_CELL_SIZE, 16'hFFFF);
    write_reg(ugnb_pkg::REG_GRID_COLS, 16'd31);
    write_reg(ugnb_pkg::REG_GRID_ROWS, 16'd0);
    write_reg(ugnb_pkg::REG_BUCKET_LIMIT, 16'd0);
    random_phase(15, 16'h7FFF);
    drain_and_settle();
    write_reg(ugnb_pkg::REG_GRID_ROWS, 16'd20);
    write_reg(ugnb_pkg::REG_BUCKET_LIMIT, 16'd7);
    write_reg(REG_SPARE_LO, 16'h1234);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    random_phase(30, 16'h7FFF);
    drain_and_settle();

    // zero cell size
    write_reg(ugnb_pkg::REG_CELL_SIZE, 16'h0000);
    random_phase(15, 1000);
    drain_and_settle();

    // dense mid-size grid
    write_reg(ugnb_pkg::REG_ORIGIN_X, 16'h0000);
    write_reg(ugnb_pkg::REG_ORIGIN_Z, 16'hF000);
    write_reg(ugnb_pkg::REG_CELL_SIZE, 16'h0040);
    write_reg(ugnb_pkg::REG_GRID_COLS, 16'd16);
    write_reg(ugnb_pkg::REG_GRID_ROWS, 16'd16);
    write_reg(ugnb_pkg::REG_BUCKET_LIMIT, 16'd4);
    random_phase(150, 16 * 64);
    quiet = 1;
    random_phase(50, 16 * 64);
    drain_and_settle();

    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
